// ----- rtl/rla_pkg.sv -----
package rla_pkg;

  localparam int PERIOD_BITS   = 32;
  localparam int LCM_BITS      = 63;
  localparam int CNT_BITS      = $clog2(PERIOD_BITS);
  localparam int IN_DATA_BITS  = 32;
  localparam int OUT_DATA_BITS = 64;

  typedef logic [PERIOD_BITS-1:0] period_t;
  typedef logic [LCM_BITS-1:0]    lcm_t;
  typedef logic [CNT_BITS-1:0]    cnt_t;

  localparam lcm_t LCM_MAX = '1;

  // status of the serial multiplier toward the sequencer
  typedef struct packed {
    logic done;
    logic ovf;
  } mul_stat_t;

endpackage

// ----- rtl/rla_gcd.sv -----
module rla_gcd import rla_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  input  lcm_t    a_in,
  input  period_t b_in,
  output logic    done,
  output period_t g_odd,
  output period_t p_sh
);

  logic    busy_r, busy_nxt;
  logic    done_r, done_nxt;
  lcm_t    a_r, a_nxt;
  period_t b_r, b_nxt;
  period_t ps_r, ps_nxt;
  lcm_t    b_ext;
  logic    same;

  assign b_ext = lcm_t'(b_r);
  assign same  = (a_r == b_ext);

  // binary gcd: one step per cycle, b never grows so it stays period wide
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    a_nxt    = a_r;
    b_nxt    = b_r;
    ps_nxt   = ps_r;
    if (start) begin
      busy_nxt = 1'b1;
      a_nxt    = a_in;
      b_nxt    = b_in;
      ps_nxt   = b_in;
    end else if (busy_r) begin
      if (same) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else if (!a_r[0] && !b_r[0]) begin
        // common factor of two, strip it from the period copy as well
        a_nxt  = a_r >> 1;
        b_nxt  = b_r >> 1;
        ps_nxt = ps_r >> 1;
      end else if (!a_r[0]) begin
        a_nxt = a_r >> 1;
      end else if (!b_r[0]) begin
        b_nxt = b_r >> 1;
      end else if (a_r > b_ext) begin
        a_nxt = (a_r - b_ext) >> 1;
      end else begin
        b_nxt = (b_r - a_r[PERIOD_BITS-1:0]) >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r  <= a_nxt;
    b_r  <= b_nxt;
    ps_r <= ps_nxt;
  end

  assign done  = done_r;
  assign g_odd = a_r[PERIOD_BITS-1:0];
  assign p_sh  = ps_r;

endmodule

// ----- rtl/rla_div.sv -----
module rla_div import rla_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  input  period_t dividend,
  input  period_t divisor,
  output logic    done,
  output period_t quotient
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  cnt_t                 cnt_r, cnt_nxt;
  period_t              rem_r, rem_nxt;
  period_t              quo_r, quo_nxt;
  logic [PERIOD_BITS:0] trial;
  logic                 fits;

  // restoring division, one quotient bit per cycle, msb first
  assign trial = {rem_r, quo_r[PERIOD_BITS-1]};
  assign fits  = (trial >= {1'b0, divisor});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = cnt_t'(PERIOD_BITS - 1);
      rem_nxt  = '0;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      rem_nxt = fits ? period_t'(trial - {1'b0, divisor}) : trial[PERIOD_BITS-1:0];
      quo_nxt = {quo_r[PERIOD_BITS-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ----- rtl/rla_mul.sv -----
module rla_mul import rla_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  lcm_t      mcand,
  input  period_t   mplier,
  output mul_stat_t stat,
  output lcm_t      product
);

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic                ovf_r, ovf_nxt;
  cnt_t                cnt_r, cnt_nxt;
  lcm_t                acc_r, acc_nxt;
  period_t             mp_r, mp_nxt;
  lcm_t                addend;
  logic [LCM_BITS+1:0] sum;

  // shift-add, multiplier bits msb first; the partial sum only grows,
  // so once it leaves the lcm range the final product does too
  assign addend = mp_r[PERIOD_BITS-1] ? mcand : '0;
  assign sum    = {1'b0, acc_r, 1'b0} + {2'b00, addend};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    ovf_nxt  = ovf_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    mp_nxt   = mp_r;
    if (start) begin
      busy_nxt = 1'b1;
      ovf_nxt  = 1'b0;
      cnt_nxt  = cnt_t'(PERIOD_BITS - 1);
      acc_nxt  = '0;
      mp_nxt   = mplier;
    end else if (busy_r) begin
      acc_nxt = sum[LCM_BITS-1:0];
      ovf_nxt = ovf_r | (sum[LCM_BITS+1:LCM_BITS] != 2'b00);
      mp_nxt  = {mp_r[PERIOD_BITS-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      ovf_r  <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      ovf_r  <= ovf_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    mp_r  <= mp_nxt;
  end

  assign stat.done = done_r;
  assign stat.ovf  = ovf_r;
  assign product   = ovf_r ? LCM_MAX : acc_r;

endmodule

// ----- rtl/running_lcm_accumulator_unit.sv -----
// Running LCM (hyperperiod) of a stream of task periods. Each request carries a
// 32-bit period in in_tdata and a start-of-set flag in in_tuser; every request
// returns one result: the running LCM (63 bits, saturated) and a sticky overflow
// flag. A request that starts a set, follows a zero running value or carries a
// zero period skips the arithmetic units: it goes from S_IDLE to S_OUT and from
// there into the output register, which raises out_tvalid. Otherwise the block
// runs three bit-serial units in turn: a binary GCD stepper (one step per cycle,
// data dependent), a restoring divider that forms period/gcd and a shift-add
// multiplier that forms running*(period/gcd); the result then passes through
// S_OUT into the output register, and the next request is taken once the block
// is back in S_IDLE. One request is worked on at a time; a new one is taken
// while the previous result still waits in the output register.
module running_lcm_accumulator_unit import rla_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [IN_DATA_BITS-1:0]  in_tdata,   // [31:0] period
  input  logic                     in_tuser,   // [0] first
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [OUT_DATA_BITS-1:0] out_tdata,  // [62:0] lcm_value
  output logic                     out_tuser   // [0] overflow
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_GCD  = 5'b00010,
    S_DIV  = 5'b00100,
    S_MUL  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t    state_r, state_nxt;
  lcm_t      lcm_r, lcm_nxt;
  logic      ovf_r, ovf_nxt;
  logic      out_valid_r, out_valid_nxt;
  lcm_t      out_lcm_r, out_lcm_nxt;
  logic      out_ovf_r, out_ovf_nxt;

  logic      in_fire;
  period_t   period;
  lcm_t      lcm_eff;
  logic      ovf_eff;
  logic      gcd_start;
  logic      gcd_done;
  period_t   gcd_odd;
  period_t   period_sh;
  logic      div_done;
  period_t   div_quo;
  mul_stat_t mul_stat;
  lcm_t      mul_prod;
  logic      out_load;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign period    = period_t'(in_tdata);
  assign lcm_eff   = in_tuser ? '0 : lcm_r;
  assign ovf_eff   = in_tuser ? 1'b0 : ovf_r;
  assign gcd_start = in_fire && (lcm_eff != '0) && (period != '0);
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || out_tready);

  rla_gcd u_gcd (
    .clk   (clk),
    .rst_n (rst_n),
    .start (gcd_start),
    .a_in  (lcm_eff),
    .b_in  (period),
    .done  (gcd_done),
    .g_odd (gcd_odd),
    .p_sh  (period_sh)
  );

  // period is exact multiple of gcd, so the quotient needs no remainder check
  rla_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (gcd_done),
    .dividend (period_sh),
    .divisor  (gcd_odd),
    .done     (div_done),
    .quotient (div_quo)
  );

  // running value stays in lcm_r until the product is back
  rla_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_done),
    .mcand   (lcm_r),
    .mplier  (div_quo),
    .stat    (mul_stat),
    .product (mul_prod)
  );

  always_comb begin
    state_nxt     = state_r;
    lcm_nxt       = lcm_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_lcm_nxt   = out_lcm_r;
    out_ovf_nxt   = out_ovf_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          ovf_nxt = ovf_eff;
          if (lcm_eff == '0) begin
            lcm_nxt   = lcm_t'(period);
            state_nxt = S_OUT;
          end else if (period == '0) begin
            lcm_nxt   = '0;
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_GCD;
          end
        end
      end
      S_GCD: begin
        if (gcd_done) begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        if (mul_stat.done) begin
          lcm_nxt   = mul_prod;
          ovf_nxt   = ovf_r | mul_stat.ovf;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_lcm_nxt   = lcm_r;
          out_ovf_nxt   = ovf_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      lcm_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lcm_r       <= lcm_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_lcm_r <= out_lcm_nxt;
    out_ovf_r <= out_ovf_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_BITS'(out_lcm_r);
  assign out_tuser  = out_ovf_r;

`ifndef ASSERT_OFF
  // lcm of two nonzero values is nonzero, saturated or not
  a_prod_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    mul_stat.done |=> (lcm_r != '0))
    else $error("running lcm zero after multiply");

  a_div_in_step: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider finished outside its step");

  a_mul_in_step: assert property (@(posedge clk) disable iff (!rst_n)
    mul_stat.done |-> (state_r == S_MUL))
    else $error("multiplier finished outside its step");

  a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (ovf_r && !(in_fire && in_tuser)) |=> ovf_r)
    else $error("overflow flag dropped within a set");

  a_out_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_OUT) && !out_valid_r) |=> (out_valid_r && (state_r == S_IDLE)))
    else $error("result not moved to output register");
`endif

endmodule

// ----- dv/tb_running_lcm_accumulator_unit.sv -----
`timescale 1ns / 1ps

module tb_running_lcm_accumulator_unit;
  import rla_pkg::*;

  typedef struct packed {
    lcm_t lcm;
    logic ovf;
  } hyper_t;

  typedef struct packed {
    period_t period;
    logic    first;
    logic    typed;
    lcm_t    lcm;
    logic    ovf;
  } dir_row_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_tvalid = 1'b0;
  logic                     in_tready;
  logic [IN_DATA_BITS-1:0]  in_tdata = '0;   // [31:0] period
  logic                     in_tuser = 1'b0; // [0] first
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] out_tdata;       // [62:0] lcm_value, [63] zero fill
  logic                     out_tuser;       // [0] overflow

  // running hyperperiod as the predictor sees it
  lcm_t     hyper_value = '0;
  logic     hyper_ovf = 1'b0;
  hyper_t   hyper_expected[$];
  int       err_count = 0;
  int       idle_in_pct = 17;
  int       idle_out_pct = 62;
  logic     hold_go = 1'b0;
  logic     hold_active = 1'b0;
  dir_row_t dir_rows[23];

  running_lcm_accumulator_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [63:0] euclid_gcd64(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] r;
    while (b != 64'd0) begin
      r = a % b;
      a = b;
      b = r;
    end
    return a;
  endfunction

  // fold one period into the running hyperperiod
  function automatic hyper_t fold_period(input period_t p, input logic first_flag);
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] g;
    logic [63:0] q;
    hyper_t      res;
    b = 64'(p);
    if (first_flag) begin
      hyper_value = '0;
      hyper_ovf = 1'b0;
    end
    if (hyper_value == '0) begin
      if (b > 64'(LCM_MAX)) begin
        hyper_value = LCM_MAX;
        hyper_ovf = 1'b1;
      end else begin
        hyper_value = lcm_t'(b);
      end
    end
    a = 64'(hyper_value);
    g = euclid_gcd64(a, b);
    if (g == 64'd0) begin
      hyper_value = '0;
    end else begin
      q = a / g;
      if (b != 64'd0 && q > 64'(LCM_MAX) / b) begin
        hyper_ovf = 1'b1;
        hyper_value = LCM_MAX;
      end else begin
        hyper_value = lcm_t'(q * b);
      end
    end
    res.lcm = hyper_value;
    res.ovf = hyper_ovf;
    return res;
  endfunction

  function automatic period_t pick_period();
    int      sel;
    period_t v;
    sel = $urandom_range(99);
    if (sel < 50) v = period_t'($urandom_range(1, 64));
    else if (sel < 65) v = period_t'($urandom_range(65, 20000));
    else if (sel < 80) v = period_t'($urandom);
    else if (sel < 86) v = '0;
    else if (sel < 93) v = period_t'(1) << $urandom_range(0, PERIOD_BITS - 1);
    else v = {1'b1, 31'($urandom)};
    return v;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("[%0t] mismatch %s: got 0x%0h want 0x%0h", $time, what, got, want);
    err_count++;
  endtask

  // offer one request; returns right after the edge that accepted it
  task automatic send_period(input period_t p, input logic f, input logic typed,
                             input lcm_t typed_lcm, input logic typed_ovf);
    hyper_t pred;
    while ($urandom_range(99) < idle_in_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= p;
    in_tuser  <= f;
    do @(posedge clk); while (!in_tready);
    pred = fold_period(p, f);
    if (typed) begin
      pred.lcm = typed_lcm;
      pred.ovf = typed_ovf;
    end
    hyper_expected.push_back(pred);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (hyper_expected.size() != 0) @(posedge clk);
  endtask

  // sets of periods: most start with first, runs of a few periods that build up
  task automatic random_sets(input int count, input int hold_at);
    int      n;
    int      run_len;
    int      k;
    logic    f;
    period_t p;
    n = 0;
    while (n < count) begin
      run_len = $urandom_range(1, 14);
      for (k = 0; k < run_len && n < count; k++) begin
        f = (k == 0) ? ($urandom_range(9) != 0) : ($urandom_range(19) == 0);
        p = pick_period();
        if (n == hold_at) hold_go = 1'b1;
        send_period(p, f, 1'b0, '0, 1'b0);
        n++;
      end
    end
  endtask

  // result side
  initial begin
    hyper_t exp_r;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        if (hyper_expected.size() == 0) begin
          report_mismatch("result with no request pending", out_tdata, 64'd0);
        end else begin
          exp_r = hyper_expected.pop_front();
          if (out_tdata[LCM_BITS-1:0] !== exp_r.lcm)
            report_mismatch("lcm_value", 64'(out_tdata[LCM_BITS-1:0]), 64'(exp_r.lcm));
          if (out_tdata[OUT_DATA_BITS-1:LCM_BITS] !== '0)
            report_mismatch("tdata fill", 64'(out_tdata[OUT_DATA_BITS-1:LCM_BITS]), 64'd0);
          if (out_tuser !== exp_r.ovf)
            report_mismatch("overflow", 64'(out_tuser), 64'(exp_r.ovf));
        end
      end
      out_tready <= !hold_active && ($urandom_range(99) >= idle_out_pct);
    end
  end

  // long receiver hold-off so the block backs up into its input
  initial begin
    wait (hold_go);
    @(posedge clk);
    hold_active <= 1'b1;
    repeat (400) @(posedge clk);
    hold_active <= 1'b0;
  end

  initial begin
    #10_000_000;
    $display("[running_lcm_accumulator_unit] ERROR");
    $finish;
  end

  initial begin
    dir_rows = '{
      '{32'd12,         1'b0, 1'b1, 63'd12,         1'b0},
      '{32'd18,         1'b0, 1'b1, 63'd36,         1'b0},
      '{32'd0,          1'b0, 1'b1, 63'd0,          1'b0},
      '{32'd7,          1'b0, 1'b1, 63'd7,          1'b0},
      '{32'd7,          1'b0, 1'b1, 63'd7,          1'b0},
      '{32'hFFFF_FFFF,  1'b1, 1'b1, 63'hFFFF_FFFF,  1'b0},
      '{32'hFFFF_FFFE,  1'b0, 1'b1, LCM_MAX,        1'b1},
      '{32'd3,          1'b0, 1'b0, '0,             1'b0},
      '{32'd0,          1'b0, 1'b1, 63'd0,          1'b1},
      '{32'd5,          1'b0, 1'b1, 63'd5,          1'b1},
      '{32'd1,          1'b1, 1'b1, 63'd1,          1'b0},
      '{32'd0,          1'b1, 1'b1, 63'd0,          1'b0},
      '{32'd1,          1'b0, 1'b1, 63'd1,          1'b0},
      '{32'h8000_0000,  1'b1, 1'b1, 63'h8000_0000,  1'b0},
      '{32'h7FFF_FFFF,  1'b0, 1'b0, '0,             1'b0},
      '{32'hFFFF_FFFF,  1'b0, 1'b0, '0,             1'b0},
      '{32'h5555_5555,  1'b1, 1'b0, '0,             1'b0},
      '{32'hAAAA_AAAA,  1'b0, 1'b0, '0,             1'b0},
      '{32'd12,         1'b1, 1'b0, '0,             1'b0},
      '{32'd8,          1'b0, 1'b0, '0,             1'b0},
      '{32'd30,         1'b0, 1'b0, '0,             1'b0},
      '{32'd7,          1'b0, 1'b0, '0,             1'b0},
      '{32'd1,          1'b0, 1'b0, '0,             1'b0}
    };
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    foreach (dir_rows[i])
      send_period(dir_rows[i].period, dir_rows[i].first, dir_rows[i].typed,
                  dir_rows[i].lcm, dir_rows[i].ovf);
    drain_results();

    random_sets(250, -1);
    drain_results();

    idle_in_pct = 62;
    idle_out_pct = 17;
    random_sets(250, -1);
    drain_results();

    idle_in_pct = 0;
    idle_out_pct = 0;
    random_sets(250, 60);
    drain_results();

    repeat (200) @(posedge clk);
    if (err_count == 0) begin
      $display("[running_lcm_accumulator_unit] OK");
    end else begin
      $display("[running_lcm_accumulator_unit] ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/rla_pkg.sv
rtl/rla_gcd.sv
rtl/rla_div.sv
rtl/rla_mul.sv
rtl/running_lcm_accumulator_unit.sv
dv/tb_running_lcm_accumulator_unit.sv
